@@ hdl/scts_pkg.sv @@
// Shared types, character codes, keyword table and helpers for the token scanner.
`timescale 1ns / 1ps

package scts_pkg;

   localparam int KEYWORD_CHARS_DEF = 6;
   localparam int OFFSET_BITS_DEF   = 32;

   localparam logic [15:0] FIRST_LINE_RESET = 16'd1;

   // Keywords are compared over their longest spelling only
   localparam int KW_COUNT     = 4;
   localparam int KW_CMP_CHARS = 6;
   localparam int KW_BITS      = 8 * KW_CMP_CHARS;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_WORD,
      MODE_NUM,
      MODE_NUM_DOT,
      MODE_FLOAT
   } scan_mode_type;

   typedef enum logic [3:0] {
      KIND_INT    = 4'd0,
      KIND_MAIN   = 4'd1,
      KIND_RETURN = 4'd2,
      KIND_VOID   = 4'd3,
      KIND_CONST  = 4'd4,
      KIND_IDENT  = 4'd5,
      KIND_LPAREN = 4'd6,
      KIND_RPAREN = 4'd7,
      KIND_LCURLY = 4'd8,
      KIND_RCURLY = 4'd9,
      KIND_SEMI   = 4'd10,
      KIND_BAD    = 4'd11,
      KIND_FLOAT  = 4'd12
   } token_kind_type;

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_LPAREN  = 8'h28;
   localparam logic [7:0] CHAR_RPAREN  = 8'h29;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_LCURLY  = 8'h7B;
   localparam logic [7:0] CHAR_RCURLY  = 8'h7D;

   // First letter in the low byte, zero padded
   localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
      48'h0000_0074_6E69,   // int
      48'h0000_6E69_616D,   // main
      48'h6E72_7574_6572,   // return
      48'h0000_6469_6F76    // void
   };

   localparam logic [15:0] KW_LEN [KW_COUNT] = '{16'd3, 16'd4, 16'd6, 16'd4};

   typedef struct packed {
      token_kind_type kind;
      logic [63:0]    value;
      logic           ovf;
      logic [31:0]    start;
      logic [15:0]    len;
      logic [15:0]    line;
      logic [15:0]    col;
      logic [7:0]     bad;
   } result_type;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return ((b >= CHAR_LOWER_A) && (b <= CHAR_LOWER_Z)) ||
             ((b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z));
   endfunction

   function automatic logic [15:0] sat_inc16(input logic [15:0] a, input logic [1:0] inc);
      logic [16:0] s;
      s = 17'(a) + 17'(inc);
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

   // Keyword only on exact length; unused prefix bytes are zero
   function automatic token_kind_type keyword_kind(input logic [KW_BITS-1:0] prefix,
                                                   input logic [15:0] len);
      token_kind_type k;
      k = KIND_IDENT;
      for (int i = KW_COUNT - 1; i >= 0; i--) begin
         if ((len == KW_LEN[i]) && (prefix == KW_TEXT[i])) begin
            k = token_kind_type'(4'(i));
         end
      end
      return k;
   endfunction

endpackage

@@ hdl/small_c_token_scanner_core.sv @@
// Top level of the byte-serial scanner for a small C subset.
// A byte is taken into the input register, then scanned into the result group register.
// Throughput: one byte per cycle while each byte yields at most one token and the receiver
// does not stall; a byte that yields more tokens (up to three) holds the next byte until
// the result group drains, one token per cycle. Reset: synchronous, active high; clears
// mode, offsets and queues, and loads the line counter with 1.
`timescale 1ns / 1ps

module small_c_token_scanner_core #(
   parameter int KEYWORD_CHARS = scts_pkg::KEYWORD_CHARS_DEF,
   parameter int OFFSET_BITS   = scts_pkg::OFFSET_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_source_byte,
   input  logic        req_end_of_text,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_token_kind,
   output logic [63:0] rsp_constant_value,
   output logic        rsp_value_overflow,
   output logic [31:0] rsp_name_start,
   output logic [15:0] rsp_name_length,
   output logic [15:0] rsp_line_number,
   output logic [15:0] rsp_column_number,
   output logic [7:0]  rsp_offending_byte,
   output logic        rsp_last_of_run,

   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   localparam int PREFIX_IDX_W = $clog2(KEYWORD_CHARS);
   localparam int GROUP_SLOTS  = 3;
   localparam int CAND_COUNT   = 5;

   // Candidate tokens in the order they leave for one byte
   localparam int C_FLUSH     = 0;   // pending token ended by this byte
   localparam int C_DOT       = 1;   // dot that was not followed by a digit
   localparam int C_BYTE      = 2;   // single-character token or bad char
   localparam int C_FINAL     = 3;   // pending token flushed at end of text
   localparam int C_FINAL_DOT = 4;   // trailing dot flushed at end of text

   // ---------------------------------------------------------------- input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // ---------------------------------------------------------------- scanner state
   scts_pkg::scan_mode_type        mode_ff, mode_in;
   logic [63:0]                    acc_ff, acc_in;
   logic                           sat_ff, sat_in;
   logic [KEYWORD_CHARS-1:0][7:0]  prefix_ff, prefix_in;
   logic [15:0]                    len_ff, len_in;
   logic [OFFSET_BITS-1:0]         start_ff, start_in;
   logic [OFFSET_BITS-1:0]         pos_ff, pos_in;
   logic [15:0]                    line_ff, line_in;
   logic [OFFSET_BITS-1:0]         line_start_ff, line_start_in;

   // ---------------------------------------------------------------- result group
   scts_pkg::result_type           grp_ff [GROUP_SLOTS];
   scts_pkg::result_type           grp_in [GROUP_SLOTS];
   logic [1:0]                     cnt_ff, cnt_in, grp_n;

   scts_pkg::result_type           cand [CAND_COUNT];
   logic [CAND_COUNT-1:0]          cand_vld;

   logic        handled;
   logic [7:0]  digit_sub;
   logic [3:0]  digit;
   logic [67:0] acc_times_ten;
   logic        acc_wraps;
   logic        rsp_take, req_take, grp_free, proc;

   // Build one token; the column is taken against the current line start
   function automatic scts_pkg::result_type make_result(
      input scts_pkg::token_kind_type kind,
      input logic [63:0]              value,
      input logic                     ovf,
      input logic [OFFSET_BITS-1:0]   start,
      input logic [15:0]              len,
      input logic [7:0]               bad,
      input logic [15:0]              line,
      input logic [OFFSET_BITS-1:0]   line_start
   );
      scts_pkg::result_type   r;
      logic [OFFSET_BITS-1:0] diff;
      logic [63:0]            diff_wide;
      logic [63:0]            start_wide;
      diff       = start - line_start;
      diff_wide  = 64'(diff);
      start_wide = 64'(start);
      r.kind     = kind;
      r.value    = value;
      r.ovf      = ovf;
      r.start    = start_wide[31:0];
      r.len      = len;
      r.line     = line;
      r.col      = (diff_wide >= 64'd65535) ? 16'hFFFF : (diff_wide[15:0] + 16'd1);
      r.bad      = bad;
      return r;
   endfunction

   // ---------------------------------------------------------------- handshakes
   // The group register frees up when it is empty or its last token leaves now;
   // the input register then hands its word to the scanner.
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign grp_free  = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_take);
   assign proc      = in_valid_ff && grp_free;
   assign req_stall = in_valid_ff && !grp_free;
   assign req_take  = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !proc);

   // Times-ten add for the decimal accumulator; a carry out saturates
   assign digit_sub     = in_byte_ff - scts_pkg::CHAR_ZERO;
   assign digit         = digit_sub[3:0];
   assign acc_times_ten = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) + 68'(digit);
   assign acc_wraps     = sat_ff || (acc_times_ten[67:64] != 4'd0);

   // ---------------------------------------------------------------- scan logic
   always_comb begin
      mode_in       = mode_ff;
      acc_in        = acc_ff;
      sat_in        = sat_ff;
      prefix_in     = prefix_ff;
      len_in        = len_ff;
      start_in      = start_ff;
      pos_in        = pos_ff;
      line_in       = line_ff;
      line_start_in = line_start_ff;
      handled       = 1'b0;
      cand_vld      = '0;
      for (int i = 0; i < CAND_COUNT; i++) begin
         cand[i] = '0;
      end

      if (proc) begin
         // Continue or close the pending token
         unique case (mode_ff)
            scts_pkg::MODE_IDLE: begin
            end
            scts_pkg::MODE_WORD: begin
               if (scts_pkg::is_alpha(in_byte_ff)) begin
                  if (len_ff < 16'(KEYWORD_CHARS)) begin
                     prefix_in[len_ff[PREFIX_IDX_W-1:0]] = in_byte_ff;
                  end
                  len_in  = scts_pkg::sat_inc16(len_ff, 2'd1);
                  handled = 1'b1;
               end else begin
                  cand_vld[C_FLUSH] = 1'b1;
                  cand[C_FLUSH] = make_result(
                     scts_pkg::keyword_kind(prefix_ff[scts_pkg::KW_CMP_CHARS-1:0], len_ff),
                     64'd0, 1'b0, start_ff, len_ff, 8'd0, line_ff, line_start_ff);
                  mode_in = scts_pkg::MODE_IDLE;
               end
            end
            scts_pkg::MODE_NUM: begin
               if (scts_pkg::is_digit(in_byte_ff)) begin
                  acc_in  = acc_wraps ? '1 : acc_times_ten[63:0];
                  sat_in  = acc_wraps;
                  len_in  = scts_pkg::sat_inc16(len_ff, 2'd1);
                  handled = 1'b1;
               end else if (in_byte_ff == scts_pkg::CHAR_DOT) begin
                  mode_in = scts_pkg::MODE_NUM_DOT;
                  handled = 1'b1;
               end else begin
                  cand_vld[C_FLUSH] = 1'b1;
                  cand[C_FLUSH] = make_result(scts_pkg::KIND_CONST, acc_ff, sat_ff,
                     start_ff, len_ff, 8'd0, line_ff, line_start_ff);
                  mode_in = scts_pkg::MODE_IDLE;
               end
            end
            scts_pkg::MODE_NUM_DOT: begin
               if (scts_pkg::is_digit(in_byte_ff)) begin
                  len_in  = scts_pkg::sat_inc16(len_ff, 2'd2);
                  mode_in = scts_pkg::MODE_FLOAT;
                  handled = 1'b1;
               end else begin
                  // Constant, then the stray dot one byte back
                  cand_vld[C_FLUSH] = 1'b1;
                  cand[C_FLUSH] = make_result(scts_pkg::KIND_CONST, acc_ff, sat_ff,
                     start_ff, len_ff, 8'd0, line_ff, line_start_ff);
                  cand_vld[C_DOT] = 1'b1;
                  cand[C_DOT] = make_result(scts_pkg::KIND_BAD, 64'd0, 1'b0,
                     pos_ff - OFFSET_BITS'(1), 16'd1, scts_pkg::CHAR_DOT,
                     line_ff, line_start_ff);
                  mode_in = scts_pkg::MODE_IDLE;
               end
            end
            scts_pkg::MODE_FLOAT: begin
               if (scts_pkg::is_digit(in_byte_ff)) begin
                  len_in  = scts_pkg::sat_inc16(len_ff, 2'd1);
                  handled = 1'b1;
               end else begin
                  cand_vld[C_FLUSH] = 1'b1;
                  cand[C_FLUSH] = make_result(scts_pkg::KIND_FLOAT, 64'd0, 1'b0,
                     start_ff, len_ff, 8'd0, line_ff, line_start_ff);
                  mode_in = scts_pkg::MODE_IDLE;
               end
            end
            default: begin
               mode_in = scts_pkg::MODE_IDLE;
            end
         endcase

         // Scan the byte fresh when it did not extend a token
         if (!handled) begin
            priority if (scts_pkg::is_digit(in_byte_ff)) begin
               mode_in  = scts_pkg::MODE_NUM;
               start_in = pos_ff;
               acc_in   = 64'(digit);
               sat_in   = 1'b0;
               len_in   = 16'd1;
            end else if (scts_pkg::is_alpha(in_byte_ff)) begin
               mode_in      = scts_pkg::MODE_WORD;
               start_in     = pos_ff;
               prefix_in    = '0;
               prefix_in[0] = in_byte_ff;
               len_in       = 16'd1;
            end else begin
               unique case (in_byte_ff)
                  scts_pkg::CHAR_NUL, scts_pkg::CHAR_SPACE: begin
                  end
                  scts_pkg::CHAR_NEWLINE: begin
                     line_in       = scts_pkg::sat_inc16(line_ff, 2'd1);
                     line_start_in = pos_ff + OFFSET_BITS'(1);
                  end
                  scts_pkg::CHAR_LPAREN: begin
                     cand_vld[C_BYTE] = 1'b1;
                     cand[C_BYTE] = make_result(scts_pkg::KIND_LPAREN, 64'd0, 1'b0,
                        pos_ff, 16'd1, 8'd0, line_ff, line_start_ff);
                  end
                  scts_pkg::CHAR_RPAREN: begin
                     cand_vld[C_BYTE] = 1'b1;
                     cand[C_BYTE] = make_result(scts_pkg::KIND_RPAREN, 64'd0, 1'b0,
                        pos_ff, 16'd1, 8'd0, line_ff, line_start_ff);
                  end
                  scts_pkg::CHAR_LCURLY: begin
                     cand_vld[C_BYTE] = 1'b1;
                     cand[C_BYTE] = make_result(scts_pkg::KIND_LCURLY, 64'd0, 1'b0,
                        pos_ff, 16'd1, 8'd0, line_ff, line_start_ff);
                  end
                  scts_pkg::CHAR_RCURLY: begin
                     cand_vld[C_BYTE] = 1'b1;
                     cand[C_BYTE] = make_result(scts_pkg::KIND_RCURLY, 64'd0, 1'b0,
                        pos_ff, 16'd1, 8'd0, line_ff, line_start_ff);
                  end
                  scts_pkg::CHAR_SEMI: begin
                     cand_vld[C_BYTE] = 1'b1;
                     cand[C_BYTE] = make_result(scts_pkg::KIND_SEMI, 64'd0, 1'b0,
                        pos_ff, 16'd1, 8'd0, line_ff, line_start_ff);
                  end
                  default: begin
                     cand_vld[C_BYTE] = 1'b1;
                     cand[C_BYTE] = make_result(scts_pkg::KIND_BAD, 64'd0, 1'b0,
                        pos_ff, 16'd1, in_byte_ff, line_ff, line_start_ff);
                  end
               endcase
            end
         end

         pos_in = pos_ff + OFFSET_BITS'(1);

         // End of text: flush whatever the byte left pending
         if (in_last_ff) begin
            unique case (mode_in)
               scts_pkg::MODE_WORD: begin
                  cand_vld[C_FINAL] = 1'b1;
                  cand[C_FINAL] = make_result(
                     scts_pkg::keyword_kind(prefix_in[scts_pkg::KW_CMP_CHARS-1:0], len_in),
                     64'd0, 1'b0, start_in, len_in, 8'd0, line_ff, line_start_ff);
               end
               scts_pkg::MODE_NUM: begin
                  cand_vld[C_FINAL] = 1'b1;
                  cand[C_FINAL] = make_result(scts_pkg::KIND_CONST, acc_in, sat_in,
                     start_in, len_in, 8'd0, line_ff, line_start_ff);
               end
               scts_pkg::MODE_NUM_DOT: begin
                  // The dot is this very byte
                  cand_vld[C_FINAL] = 1'b1;
                  cand[C_FINAL] = make_result(scts_pkg::KIND_CONST, acc_in, sat_in,
                     start_in, len_in, 8'd0, line_ff, line_start_ff);
                  cand_vld[C_FINAL_DOT] = 1'b1;
                  cand[C_FINAL_DOT] = make_result(scts_pkg::KIND_BAD, 64'd0, 1'b0,
                     pos_ff, 16'd1, scts_pkg::CHAR_DOT, line_ff, line_start_ff);
               end
               scts_pkg::MODE_FLOAT: begin
                  cand_vld[C_FINAL] = 1'b1;
                  cand[C_FINAL] = make_result(scts_pkg::KIND_FLOAT, 64'd0, 1'b0,
                     start_in, len_in, 8'd0, line_ff, line_start_ff);
               end
               default: begin
               end
            endcase
            mode_in = scts_pkg::MODE_IDLE;
         end
      end

      // Configuration write reloads the line counter at once
      if (csr_write_enable) begin
         line_in = csr_write_data;
      end
   end

   // Pack the live candidates, in order, into the group slots
   always_comb begin
      grp_n = 2'd0;
      for (int s = 0; s < GROUP_SLOTS; s++) begin
         grp_in[s] = '0;
      end
      for (int i = 0; i < CAND_COUNT; i++) begin
         if (cand_vld[i] && (grp_n != 2'(GROUP_SLOTS))) begin
            grp_in[grp_n] = cand[i];
            grp_n         = grp_n + 2'd1;
         end
      end
   end

   // Load a fresh group, or advance the one in place by a slot
   always_comb begin
      cnt_in = cnt_ff;
      if (proc) begin
         cnt_in = grp_n;
      end else if (rsp_take) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         mode_ff       <= scts_pkg::MODE_IDLE;
         pos_ff        <= '0;
         line_ff       <= scts_pkg::FIRST_LINE_RESET;
         line_start_ff <= '0;
         cnt_ff        <= 2'd0;
      end else begin
         in_valid_ff   <= in_valid_in;
         mode_ff       <= mode_in;
         pos_ff        <= pos_in;
         line_ff       <= line_in;
         line_start_ff <= line_start_in;
         cnt_ff        <= cnt_in;
      end
   end

   // Payload: hold the word, the token fields and the group slots
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_source_byte;
         in_last_ff <= req_end_of_text;
      end
      acc_ff    <= acc_in;
      sat_ff    <= sat_in;
      prefix_ff <= prefix_in;
      len_ff    <= len_in;
      start_ff  <= start_in;
      if (proc) begin
         for (int s = 0; s < GROUP_SLOTS; s++) begin
            grp_ff[s] <= grp_in[s];
         end
      end else if (rsp_take) begin
         for (int s = 0; s < GROUP_SLOTS - 1; s++) begin
            grp_ff[s] <= grp_ff[s + 1];
         end
      end
   end

   // ---------------------------------------------------------------- outputs
   // The head slot is always the next token; the run ends when one slot is left.
   assign rsp_token_kind     = grp_ff[0].kind;
   assign rsp_constant_value = grp_ff[0].value;
   assign rsp_value_overflow = grp_ff[0].ovf;
   assign rsp_name_start     = grp_ff[0].start;
   assign rsp_name_length    = grp_ff[0].len;
   assign rsp_line_number    = grp_ff[0].line;
   assign rsp_column_number  = grp_ff[0].col;
   assign rsp_offending_byte = grp_ff[0].bad;
   assign rsp_last_of_run    = (cnt_ff == 2'd1);

endmodule

@@ hdl/scts_checker.sv @@
// Port-level checks on the token scanner, bound to the top level.
`timescale 1ns / 1ps

module scts_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_token_kind,
   input logic [63:0] rsp_constant_value,
   input logic        rsp_value_overflow,
   input logic [31:0] rsp_name_start,
   input logic [15:0] rsp_name_length,
   input logic [7:0]  rsp_offending_byte,
   input logic        rsp_last_of_run
);

   // A stalled token holds its place and fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_token_kind) &&
         $stable(rsp_constant_value) && $stable(rsp_name_start) &&
         $stable(rsp_last_of_run))
      else $error("stalled token changed");

   // Reset drops any queued tokens
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("token valid right after reset");

   // Only constants carry a value or an overflow flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind != scts_pkg::KIND_CONST) |->
         (rsp_constant_value == 64'd0) && !rsp_value_overflow)
      else $error("value on a non-constant token");

   // A saturated constant reads as all ones
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_value_overflow |-> (rsp_constant_value == '1))
      else $error("overflowed constant not saturated");

   // A bad char is one byte wide and never the skipped NUL byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind == scts_pkg::KIND_BAD) |->
         (rsp_name_length == 16'd1) && (rsp_offending_byte != scts_pkg::CHAR_NUL))
      else $error("malformed bad char token");

endmodule

bind small_c_token_scanner_core scts_checker u_scts_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_token_kind     (rsp_token_kind),
   .rsp_constant_value (rsp_constant_value),
   .rsp_value_overflow (rsp_value_overflow),
   .rsp_name_start     (rsp_name_start),
   .rsp_name_length    (rsp_name_length),
   .rsp_offending_byte (rsp_offending_byte),
   .rsp_last_of_run    (rsp_last_of_run)
);

@@ bench/small_c_token_scanner_core_tb.sv @@
// Self-checking bench for the byte-serial C token scanner core.
`timescale 1ns / 1ps

module small_c_token_scanner_core_tb;

   // Cycles in which neither channel moves a word before the run is declared hung
   localparam int STALL_LIMIT     = 4000;
   // Quiet cycles after the last token before a register write
   localparam int SETTLE_CYCLES   = 8;
   // Quiet cycles at the very end, to catch stray tokens
   localparam int TAIL_CYCLES     = 12;
   localparam int MAX_REPORTS     = 60;

   // One source byte waiting to be sent; drain_first holds it back until
   // every token predicted so far has been taken
   typedef struct packed {
      logic [7:0] text_byte;
      logic       last_byte;
      logic       drain_first;
   } source_word_type;

   typedef struct packed {
      scts_pkg::token_kind_type kind;
      logic [63:0]              value;
      logic                     ovf;
      logic [31:0]              start;
      logic [15:0]              len;
      logic [15:0]              line;
      logic [15:0]              col;
      logic [7:0]               bad;
      logic                     last;
   } scanned_token_type;

   logic        clock;
   logic        reset              = 1'b1;
   logic        req_valid          = 1'b0;
   logic        req_stall;
   logic [7:0]  req_source_byte    = 8'd0;
   logic        req_end_of_text    = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall          = 1'b0;
   logic [3:0]  rsp_token_kind;
   logic [63:0] rsp_constant_value;
   logic        rsp_value_overflow;
   logic [31:0] rsp_name_start;
   logic [15:0] rsp_name_length;
   logic [15:0] rsp_line_number;
   logic [15:0] rsp_column_number;
   logic [7:0]  rsp_offending_byte;
   logic        rsp_last_of_run;
   logic        csr_write_enable   = 1'b0;
   logic [15:0] csr_write_data     = 16'd0;

   source_word_type   source_text[$];
   scanned_token_type tokens_due[$];
   scanned_token_type step_tokens[$];

   int unsigned send_idle_pct  = 14;
   int unsigned recv_stall_pct = 69;
   int unsigned quiet_cycles   = 0;
   int unsigned mismatch_count = 0;
   bit          word_taken     = 1'b0;

   // Scanner state as the bench sees it
   scts_pkg::scan_mode_type      scan_state;
   logic [63:0]                  num_acc;
   logic                         num_sat;
   logic [scts_pkg::KW_BITS-1:0] word_head;    // first letters, latest in the low byte
   logic [15:0]                  tok_len;
   logic [31:0]                  tok_start;
   logic [31:0]                  byte_pos;
   logic [15:0]                  line_now;
   logic [31:0]                  line_head;    // offset of the first byte of the current line

   small_c_token_scanner_core DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_source_byte    (req_source_byte),
      .req_end_of_text    (req_end_of_text),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_token_kind     (rsp_token_kind),
      .rsp_constant_value (rsp_constant_value),
      .rsp_value_overflow (rsp_value_overflow),
      .rsp_name_start     (rsp_name_start),
      .rsp_name_length    (rsp_name_length),
      .rsp_line_number    (rsp_line_number),
      .rsp_column_number  (rsp_column_number),
      .rsp_offending_byte (rsp_offending_byte),
      .rsp_last_of_run    (rsp_last_of_run),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Token prediction
   // ---------------------------------------------------------------------

   function automatic logic [15:0] add_sat16(input logic [15:0] a, input logic [15:0] inc);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, inc};
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

   function automatic bit is_num_char(input logic [7:0] b);
      return (b >= scts_pkg::CHAR_ZERO) && (b <= scts_pkg::CHAR_NINE);
   endfunction

   function automatic bit is_letter_char(input logic [7:0] b);
      return ((b >= scts_pkg::CHAR_LOWER_A) && (b <= scts_pkg::CHAR_LOWER_Z)) ||
             ((b >= scts_pkg::CHAR_UPPER_A) && (b <= scts_pkg::CHAR_UPPER_Z));
   endfunction

   // Append one token to this byte's group; the column is counted from the
   // start of the current line and pinned at the 16-bit ceiling
   function automatic void push_token(input scts_pkg::token_kind_type kind,
                                      input logic [63:0] value,
                                      input logic ovf, input logic [31:0] start,
                                      input logic [15:0] len, input logic [7:0] bad);
      scanned_token_type t;
      logic [32:0]       col;
      col     = {1'b0, start - line_head} + 33'd1;
      t.kind  = kind;
      t.value = value;
      t.ovf   = ovf;
      t.start = start;
      t.len   = len;
      t.line  = line_now;
      t.col   = (col > 33'd65535) ? 16'hFFFF : col[15:0];
      t.bad   = bad;
      t.last  = 1'b0;
      if (step_tokens.size() < 3)
         step_tokens = {step_tokens, t};
   endfunction

   // Keywords match only on their exact length
   function automatic void push_word();
      scts_pkg::token_kind_type kind;
      if (tok_len == 16'd3 && word_head == {24'd0, "int"})
         kind = scts_pkg::KIND_INT;
      else if (tok_len == 16'd4 && word_head == {16'd0, "main"})
         kind = scts_pkg::KIND_MAIN;
      else if (tok_len == 16'd6 && word_head == "return")
         kind = scts_pkg::KIND_RETURN;
      else if (tok_len == 16'd4 && word_head == {16'd0, "void"})
         kind = scts_pkg::KIND_VOID;
      else
         kind = scts_pkg::KIND_IDENT;
      push_token(kind, 64'd0, 1'b0, tok_start, tok_len, 8'd0);
   endfunction

   function automatic void push_number();
      push_token(scts_pkg::KIND_CONST, num_acc, num_sat, tok_start, tok_len, 8'd0);
   endfunction

   // The dot is always the byte just before the current position
   function automatic void push_dot();
      push_token(scts_pkg::KIND_BAD, 64'd0, 1'b0, byte_pos - 32'd1, 16'd1,
                 scts_pkg::CHAR_DOT);
   endfunction

   function automatic void push_float();
      push_token(scts_pkg::KIND_FLOAT, 64'd0, 1'b0, tok_start, tok_len, 8'd0);
   endfunction

   function automatic void take_digit(input logic [7:0] b);
      logic [63:0] d;
      d = {56'd0, b - scts_pkg::CHAR_ZERO};
      if (num_sat || num_acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) begin
         num_acc = 64'hFFFF_FFFF_FFFF_FFFF;
         num_sat = 1'b1;
      end else begin
         num_acc = num_acc * 64'd10 + d;
      end
   endfunction

   function automatic void take_letter(input logic [7:0] b);
      if (tok_len < 16'(scts_pkg::KEYWORD_CHARS_DEF))
         word_head = {word_head[scts_pkg::KW_BITS-9:0], b};
      tok_len = add_sat16(tok_len, 16'd1);
   endfunction

   // Advance the scanner by one byte and queue the tokens it yields
   function automatic void scan_byte(input logic [7:0] b, input logic eot);
      bit consumed;
      consumed = 1'b0;
      step_tokens.delete();

      // Continue or close the token in progress
      case (scan_state)
         scts_pkg::MODE_WORD: begin
            if (is_letter_char(b)) begin
               take_letter(b);
               consumed = 1'b1;
            end else begin
               push_word();
               scan_state = scts_pkg::MODE_IDLE;
            end
         end
         scts_pkg::MODE_NUM: begin
            if (is_num_char(b)) begin
               take_digit(b);
               tok_len  = add_sat16(tok_len, 16'd1);
               consumed = 1'b1;
            end else if (b == scts_pkg::CHAR_DOT) begin
               scan_state = scts_pkg::MODE_NUM_DOT;
               consumed   = 1'b1;
            end else begin
               push_number();
               scan_state = scts_pkg::MODE_IDLE;
            end
         end
         scts_pkg::MODE_NUM_DOT: begin
            if (is_num_char(b)) begin
               tok_len    = add_sat16(tok_len, 16'd2);
               scan_state = scts_pkg::MODE_FLOAT;
               consumed   = 1'b1;
            end else begin
               push_number();
               push_dot();
               scan_state = scts_pkg::MODE_IDLE;
            end
         end
         scts_pkg::MODE_FLOAT: begin
            if (is_num_char(b)) begin
               tok_len  = add_sat16(tok_len, 16'd1);
               consumed = 1'b1;
            end else begin
               push_float();
               scan_state = scts_pkg::MODE_IDLE;
            end
         end
         default: scan_state = scts_pkg::MODE_IDLE;
      endcase

      // A byte not absorbed above is scanned from scratch
      if (!consumed) begin
         if (is_num_char(b)) begin
            scan_state = scts_pkg::MODE_NUM;
            tok_start  = byte_pos;
            num_acc    = 64'd0;
            num_sat    = 1'b0;
            tok_len    = 16'd1;
            take_digit(b);
         end else if (is_letter_char(b)) begin
            scan_state = scts_pkg::MODE_WORD;
            tok_start  = byte_pos;
            word_head  = '0;
            tok_len    = 16'd0;
            take_letter(b);
         end else begin
            case (b)
               scts_pkg::CHAR_NUL, scts_pkg::CHAR_SPACE: ;
               scts_pkg::CHAR_NEWLINE: begin
                  line_now  = add_sat16(line_now, 16'd1);
                  line_head = byte_pos + 32'd1;
               end
               scts_pkg::CHAR_LPAREN:
                  push_token(scts_pkg::KIND_LPAREN, 64'd0, 1'b0, byte_pos, 16'd1, 8'd0);
               scts_pkg::CHAR_RPAREN:
                  push_token(scts_pkg::KIND_RPAREN, 64'd0, 1'b0, byte_pos, 16'd1, 8'd0);
               scts_pkg::CHAR_LCURLY:
                  push_token(scts_pkg::KIND_LCURLY, 64'd0, 1'b0, byte_pos, 16'd1, 8'd0);
               scts_pkg::CHAR_RCURLY:
                  push_token(scts_pkg::KIND_RCURLY, 64'd0, 1'b0, byte_pos, 16'd1, 8'd0);
               scts_pkg::CHAR_SEMI:
                  push_token(scts_pkg::KIND_SEMI, 64'd0, 1'b0, byte_pos, 16'd1, 8'd0);
               default:
                  push_token(scts_pkg::KIND_BAD, 64'd0, 1'b0, byte_pos, 16'd1, b);
            endcase
         end
      end
      byte_pos = byte_pos + 32'd1;

      // End of text flushes whatever is still open
      if (eot) begin
         case (scan_state)
            scts_pkg::MODE_WORD:    push_word();
            scts_pkg::MODE_NUM:     push_number();
            scts_pkg::MODE_NUM_DOT: begin
               push_number();
               push_dot();
            end
            scts_pkg::MODE_FLOAT:   push_float();
            default: ;
         endcase
         scan_state = scts_pkg::MODE_IDLE;
      end

      // Mark the closing token of the group, then hand the group over
      if (step_tokens.size() != 0) begin
         scanned_token_type t;
         t      = step_tokens.pop_back();
         t.last = 1'b1;
         step_tokens = {step_tokens, t};
      end
      tokens_due = {tokens_due, step_tokens};
   endfunction

   // ---------------------------------------------------------------------
   // Source text construction
   // ---------------------------------------------------------------------

   function automatic void queue_byte(input logic [7:0] b, input logic eot, input logic drain);
      source_word_type w;
      w.text_byte   = b;
      w.last_byte   = eot;
      w.drain_first = drain;
      source_text   = {source_text, w};
   endfunction

   function automatic void queue_text(input string s, input logic eot_at_end);
      for (int i = 0; i < s.len(); i++)
         queue_byte(s[i], eot_at_end && (i == s.len() - 1), 1'b0);
   endfunction

   function automatic void queue_digits(input int unsigned n);
      repeat (n) queue_byte(scts_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0, 1'b0);
   endfunction

   // Mostly well-formed C fragments with random content, some noise and
   // broken numbers; the phase always closes with an end-of-text byte
   function automatic void queue_random_text(input int unsigned target);
      int unsigned     made;
      int unsigned     mark;
      int unsigned     pick;
      string           kw;
      logic [7:0]      c;
      source_word_type w;
      made = 0;
      while (made < target) begin
         mark = source_text.size();
         pick = $urandom_range(0, 19);
         if (pick <= 3) begin
            // Keyword, sometimes one letter off
            case ($urandom_range(0, 3))
               0: kw = "int";
               1: kw = "main";
               2: kw = "return";
               default: kw = "void";
            endcase
            case ($urandom_range(0, 4))
               2: kw = {kw, "s"};
               3: kw = kw.substr(0, kw.len() - 2);
               4: kw[0] = kw[0] - 8'h20;
               default: ;
            endcase
            queue_text(kw, 1'b0);
         end else if (pick <= 6) begin
            // Identifier, now and then longer than the kept prefix
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6))
               queue_byte($urandom_range(0, 1)
                             ? scts_pkg::CHAR_LOWER_A + 8'($urandom_range(0, 25))
                             : scts_pkg::CHAR_UPPER_A + 8'($urandom_range(0, 25)),
                          1'b0, 1'b0);
         end else if (pick <= 9) begin
            // Constant, with the saturation edge and plain overflow
            case ($urandom_range(0, 9))
               0:       queue_text("18446744073709551615", 1'b0);
               1:       queue_text("18446744073709551616", 1'b0);
               2, 3:    queue_digits($urandom_range(18, 24));
               default: queue_digits($urandom_range(1, 4));
            endcase
         end else if (pick <= 11) begin
            queue_digits($urandom_range(1, 3));
            queue_byte(scts_pkg::CHAR_DOT, 1'b0, 1'b0);
            queue_digits($urandom_range(1, 3));
         end else if (pick == 12) begin
            // Number with a dot that no digit follows
            queue_digits($urandom_range(1, 3));
            queue_byte(scts_pkg::CHAR_DOT, 1'b0, 1'b0);
            if ($urandom_range(0, 1)) begin
               c = 8'($urandom_range(0, 255));
               while (is_num_char(c))
                  c = 8'($urandom_range(0, 255));
               queue_byte(c, 1'b0, 1'b0);
            end
         end else if (pick <= 16) begin
            case ($urandom_range(0, 4))
               0:       queue_byte(scts_pkg::CHAR_LPAREN, 1'b0, 1'b0);
               1:       queue_byte(scts_pkg::CHAR_RPAREN, 1'b0, 1'b0);
               2:       queue_byte(scts_pkg::CHAR_LCURLY, 1'b0, 1'b0);
               3:       queue_byte(scts_pkg::CHAR_RCURLY, 1'b0, 1'b0);
               default: queue_byte(scts_pkg::CHAR_SEMI, 1'b0, 1'b0);
            endcase
         end else if (pick <= 18) begin
            case ($urandom_range(0, 3))
               0, 1:    queue_byte(scts_pkg::CHAR_SPACE, 1'b0, 1'b0);
               2:       queue_byte(scts_pkg::CHAR_NEWLINE, 1'b0, 1'b0);
               default: queue_byte(scts_pkg::CHAR_NUL, 1'b0, 1'b0);
            endcase
         end else begin
            queue_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         end

         // Cut the text short now and then, and sometimes let the
         // pipeline run dry before the closing byte of a fragment
         w = source_text.pop_back();
         if ($urandom_range(0, 29) == 0)
            w.last_byte = 1'b1;
         if ($urandom_range(0, 49) == 0)
            w.drain_first = 1'b1;
         source_text = {source_text, w};
         made += source_text.size() - mark;
      end
      w = source_text.pop_back();
      w.last_byte = 1'b1;
      source_text = {source_text, w};
   endfunction

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------

   task automatic flag_mismatch(input string what);
      if (mismatch_count < MAX_REPORTS)
         $display("%0t mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         flag_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
   endtask

   // Block until every byte is sent and every predicted token has come back
   task automatic await_drain();
      while (source_text.size() != 0 || tokens_due.size() != 0)
         @(posedge clock);
   endtask

   // Write the line register once the scanner has gone quiet. Return on a
   // rising edge so that new text is queued away from the driver's edge.
   task automatic set_first_line(input logic [15:0] value);
      await_drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      line_now = value;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Source driver
   // ---------------------------------------------------------------------

   // Retire the word taken at this edge and predict its tokens
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         scan_byte(req_source_byte, req_end_of_text);
         void'(source_text.pop_front());
         word_taken = 1'b1;
      end
   end

   // Present the next word on the falling edge; hold a word that has not
   // been taken yet, and idle at random between words
   always @(negedge clock) begin : feed_source
      source_word_type w;
      w = '0;
      if (source_text.size() != 0)
         w = source_text[0];
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !word_taken) begin
         // hold
      end else if (source_text.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
                   !(w.drain_first && tokens_due.size() != 0)) begin
         req_valid       <= 1'b1;
         req_source_byte <= w.text_byte;
         req_end_of_text <= w.last_byte;
      end else begin
         req_valid <= 1'b0;
      end
      word_taken = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Token monitor
   // ---------------------------------------------------------------------

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // Compare each taken token with the oldest prediction
   always @(posedge clock) begin : check_tokens
      scanned_token_type t;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tokens_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected token kind %0d at offset %0d",
                                    rsp_token_kind, rsp_name_start));
         end else begin
            t = tokens_due.pop_front();
            check_field("kind", rsp_token_kind, t.kind);
            check_field("value", rsp_constant_value, t.value);
            check_field("overflow", rsp_value_overflow, t.ovf);
            check_field("start", rsp_name_start, t.start);
            check_field("length", rsp_name_length, t.len);
            check_field("line", rsp_line_number, t.line);
            check_field("column", rsp_column_number, t.col);
            check_field("offending byte", rsp_offending_byte, t.bad);
            check_field("last of run", rsp_last_of_run, t.last);
         end
      end
   end

   // Count cycles in which neither channel moves a word
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      scan_state = scts_pkg::MODE_IDLE;
      num_acc    = 64'd0;
      num_sat    = 1'b0;
      word_head  = '0;
      tok_len    = 16'd0;
      tok_start  = 32'd0;
      byte_pos   = 32'd0;
      line_now   = scts_pkg::FIRST_LINE_RESET;
      line_head  = 32'd0;

      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      fork
         begin
            // Directed text at the reset line number: keywords and brackets,
            // a word running into a float that ends on a second dot, a dot
            // with no digit after it (three tokens from one byte), bytes
            // 0xFF and NUL, a dot at end of text, then a new line.
            // The sender holds off before the 7 until the pipeline is empty.
            queue_text("int main(){", 1'b0);
            queue_text("a1.5.", 1'b0);
            queue_byte(scts_pkg::CHAR_ZERO + 8'd7, 1'b0, 1'b1);
            queue_text(".#", 1'b0);
            queue_byte(8'hFF, 1'b0, 1'b0);
            queue_byte(scts_pkg::CHAR_NUL, 1'b0, 1'b0);
            queue_text("4.", 1'b1);
            queue_text("\n};", 1'b1);

            // Line numbers from zero, slow receiver
            set_first_line(16'd0);
            queue_random_text(130);

            // Line count runs into its ceiling, slow sender
            set_first_line(16'd65534);
            send_idle_pct  = 69;
            recv_stall_pct = 14;
            queue_text("\n;\n\n;", 1'b1);
            queue_random_text(130);

            // Top line number, no idling
            set_first_line(16'd65535);
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            queue_random_text(130);
            queue_text(" ;", 1'b1);

            await_drain();
            repeat (TAIL_CYCLES) @(posedge clock);
            if (tokens_due.size() != 0)
               flag_mismatch($sformatf("%0d tokens never arrived", tokens_due.size()));
         end
         wait (quiet_cycles >= STALL_LIMIT);
      join_any

      if (quiet_cycles >= STALL_LIMIT)
         $display("Regression FAIL");
      else if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
